// File: sv/osde_pkg.sv
// ----------------------------------------------------------------------------
// osde_pkg
// Shared types and constants of the odometry speed and direction estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package osde_pkg;

    localparam int TIME_W       = 32;
    localparam int HEAD_W       = 17;
    localparam int THR_W        = 16;
    localparam int SPEED_W      = 33;
    localparam int GUARD_BITS   = 20;
    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int HWRAP_W      = 18;
    localparam int ANGLE_W      = 34;
    localparam int ATAN_W       = 32;

    localparam logic [THR_W-1:0]   THR_RESET = 16'd328;
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    // heading limits in hundredths of a degree
    localparam logic signed [HWRAP_W-1:0] FULL_TURN    = 18'sd36000;
    localparam logic signed [HWRAP_W-1:0] HALF_TURN    = 18'sd18000;
    localparam logic signed [HWRAP_W-1:0] QUARTER_TURN = 18'sd9000;

    // atan(2^-i) in units of 1/65536 hundredth of a degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
        32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
        32'd1466764,   32'd733385,    32'd366693,   32'd183347,
        32'd91673,     32'd45837,     32'd22918,    32'd11459,
        32'd5730,      32'd2865,      32'd1432,     32'd716,
        32'd358,       32'd179,       32'd90,       32'd45
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_DIV,
        ST_DIR,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_WRAP,
        CS_ROT
    } t_cord_state;

endpackage

`default_nettype wire

// File: sv/osde_if.sv
// ----------------------------------------------------------------------------
// osde_if
// Valid/ready channels: odometry sample, estimate result and threshold write.
// ----------------------------------------------------------------------------
`default_nettype none

interface osde_sample_if #(
    parameter int POS_WIDTH = 16
);
    logic                                  valid;
    logic                                  ready;
    logic [osde_pkg::TIME_W-1:0]           local_time;
    logic [osde_pkg::TIME_W-1:0]           remote_time;
    logic signed [POS_WIDTH-1:0]           pos_x;
    logic signed [POS_WIDTH-1:0]           pos_y;
    logic signed [osde_pkg::HEAD_W-1:0]    heading;

    modport source (output valid, local_time, remote_time, pos_x, pos_y, heading,
                    input ready);
    modport sink   (input valid, local_time, remote_time, pos_x, pos_y, heading,
                    output ready);
endinterface

interface osde_result_if;
    logic                          valid;
    logic                          ready;
    logic [osde_pkg::SPEED_W-1:0]  speed;
    logic                          moving_forward;
    logic                          sample_used;

    modport source (output valid, speed, moving_forward, sample_used, input ready);
    modport sink   (input valid, speed, moving_forward, sample_used, output ready);
endinterface

interface osde_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [osde_pkg::THR_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/osde_sqrt.sv
// ----------------------------------------------------------------------------
// osde_sqrt
// Floor integer square root, one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osde_sqrt #(
    parameter int OUT_W = 17
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [2*OUT_W-1:0] i_radicand,
    output logic                    o_done,
    output logic [OUT_W-1:0]        o_root
);
    localparam int CNT_W = $clog2(OUT_W);

    logic                 r_busy, r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [2*OUT_W-1:0]   r_rad;
    logic [OUT_W+1:0]     r_rem;
    logic [OUT_W-1:0]     r_root;
    logic [OUT_W+3:0]     n_rem_sh;
    logic [OUT_W+3:0]     n_trial;
    logic                 n_take;

    // trial subtraction of (4*root + 1)
    always_comb begin
        n_rem_sh = {r_rem, r_rad[2*OUT_W-1 -: 2]};
        n_trial  = {2'b00, r_root, 2'b01};
        n_take   = (n_rem_sh >= n_trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OUT_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*OUT_W-3:0], 2'b00};
            r_rem  <= n_take ? (OUT_W+2)'(n_rem_sh - n_trial) : n_rem_sh[OUT_W+1:0];
            r_root <= {r_root[OUT_W-2:0], n_take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: sv/osde_div.sv
// ----------------------------------------------------------------------------
// osde_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module osde_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic               r_busy, r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W:0]     n_rem_sh;
    logic               n_take;

    always_comb begin
        n_rem_sh = {r_rem, r_num[NUM_W-1]};
        n_take   = (n_rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], n_take};
            r_rem <= n_take ? DEN_W'(n_rem_sh - {1'b0, r_den}) : n_rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

// File: sv/osde_cordic.sv
// ----------------------------------------------------------------------------
// osde_cordic
// Direction test: rotates (dx,dy) by -heading, one CORDIC step per cycle,
// and reports whether the rotated x is positive.
// ----------------------------------------------------------------------------
`default_nettype none

module osde_cordic #(
    parameter int D_W = 17
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [D_W-1:0]               i_dx,
    input  wire logic signed [D_W-1:0]               i_dy,
    input  wire logic signed [osde_pkg::HEAD_W-1:0]  i_heading,
    output logic                                     o_done,
    output logic                                     o_forward
);
    localparam int VEC_W = D_W + osde_pkg::GUARD_BITS + 2;

    osde_pkg::t_cord_state                    r_state, n_state;
    logic [osde_pkg::ITER_W-1:0]              r_iter;
    logic                                     r_done;
    logic signed [VEC_W-1:0]                  r_x, r_y;
    logic signed [osde_pkg::ANGLE_W-1:0]      r_z;
    logic signed [osde_pkg::HWRAP_W-1:0]      r_h;
    logic signed [VEC_W-1:0]                  n_xs, n_ys;
    logic signed [osde_pkg::ANGLE_W-1:0]      n_atan;
    logic                                     n_wrap_hi, n_wrap_lo, n_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            osde_pkg::CS_IDLE: if (i_start) n_state = osde_pkg::CS_WRAP;
            osde_pkg::CS_WRAP: if (!n_wrap_hi && !n_wrap_lo) n_state = osde_pkg::CS_ROT;
            osde_pkg::CS_ROT:  if (n_last) n_state = osde_pkg::CS_IDLE;
            default:           n_state = osde_pkg::CS_IDLE;
        endcase
    end

    // step terms
    always_comb begin
        n_wrap_hi = (r_h >= osde_pkg::HALF_TURN);
        n_wrap_lo = (r_h < -osde_pkg::HALF_TURN);
        n_last    = (r_iter == osde_pkg::ITER_W'(osde_pkg::CORDIC_ITERS-1));
        n_xs      = r_x >>> r_iter;
        n_ys      = r_y >>> r_iter;
        n_atan    = $signed({2'b00, osde_pkg::ATAN_TAB[r_iter]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= osde_pkg::CS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == osde_pkg::CS_ROT) && n_last;
        end
    end

    // datapath: heading wrap, half-plane fold, then rotation
    always_ff @(posedge i_clk) begin
        case (r_state)
            osde_pkg::CS_IDLE: begin
                if (i_start) begin
                    r_x    <= VEC_W'(i_dx) <<< osde_pkg::GUARD_BITS;
                    r_y    <= VEC_W'(i_dy) <<< osde_pkg::GUARD_BITS;
                    r_h    <= osde_pkg::HWRAP_W'(i_heading);
                    r_iter <= '0;
                end
            end
            osde_pkg::CS_WRAP: begin
                if (n_wrap_hi) begin
                    r_h <= r_h - osde_pkg::FULL_TURN;
                end else if (n_wrap_lo) begin
                    r_h <= r_h + osde_pkg::FULL_TURN;
                end else if (r_h > osde_pkg::QUARTER_TURN) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                    r_z <= osde_pkg::ANGLE_W'(r_h - osde_pkg::HALF_TURN) <<< 16;
                end else if (r_h < -osde_pkg::QUARTER_TURN) begin
                    r_x <= -r_x;
                    r_y <= -r_y;
                    r_z <= osde_pkg::ANGLE_W'(r_h + osde_pkg::HALF_TURN) <<< 16;
                end else begin
                    r_z <= osde_pkg::ANGLE_W'(r_h) <<< 16;
                end
            end
            osde_pkg::CS_ROT: begin
                if (r_z >= 0) begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z - n_atan;
                end else begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z + n_atan;
                end
                r_iter <= r_iter + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done    = r_done;
    assign o_forward = (r_x > 0);

endmodule

`default_nettype wire

// File: sv/odometry_speed_direction_estimator.sv
// ----------------------------------------------------------------------------
// odometry_speed_direction_estimator
// Speed magnitude and travel direction from successive odometry samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time and gives one result. A repeated local time
// or the first (priming) sample goes from acceptance straight to the output
// state. A moving sample runs the squaring states ST_SQX and ST_SQY, the
// square root (one root bit per cycle), the divider (one quotient bit per
// cycle, skipped when the remote time difference is zero) and, when speed is
// above the threshold, the CORDIC (heading wrap and half-plane fold, then 24
// rotation steps), then loads the output register once it is free. A new
// sample is taken while the previous result still waits in the output
// register. The threshold is to be written on its own channel while idle;
// the block itself does not enforce this.
`default_nettype none

module odometry_speed_direction_estimator #(
    parameter int POS_WIDTH = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    osde_sample_if.sink      i_sample,
    osde_result_if.source    o_result,
    osde_cfg_if.sink         i_cfg
);
    localparam int D_W   = POS_WIDTH + 1;
    localparam int SQ_W  = 2 * D_W;
    localparam int Q_W   = D_W + FRAC_BITS;
    localparam int CMP_W = (Q_W > osde_pkg::SPEED_W) ? Q_W : osde_pkg::SPEED_W;
    localparam int TW    = osde_pkg::TIME_W;

    osde_pkg::t_state                   r_state, n_state;
    logic                               r_primed;
    logic [TW-1:0]                      r_prev_lt, r_prev_rt, r_dt;
    logic signed [POS_WIDTH-1:0]        r_prev_x, r_prev_y;
    logic signed [D_W-1:0]              r_dx, r_dy;
    logic signed [osde_pkg::HEAD_W-1:0] r_hd;
    logic [SQ_W-1:0]                    r_sq;
    logic [osde_pkg::SPEED_W-1:0]       r_speed;
    logic                               r_fwd, r_used;
    logic [osde_pkg::THR_W-1:0]         r_thr;
    logic                               r_o_valid, r_o_fwd, r_o_used;
    logic [osde_pkg::SPEED_W-1:0]       r_o_speed;

    logic                               n_accept, n_changed, n_load;
    logic [TW-1:0]                      n_d;
    logic signed [SQ_W-1:0]             n_mul;
    logic signed [D_W-1:0]              n_mul_op;
    logic [SQ_W-1:0]                    n_radicand;
    logic                               sqrt_start, sqrt_done;
    logic [D_W-1:0]                     root;
    logic                               div_start, div_done;
    logic [Q_W-1:0]                     quot;
    logic [CMP_W-1:0]                   n_quot_ext;
    logic [osde_pkg::SPEED_W-1:0]       n_speed;
    logic                               cord_start, cord_done, cord_fwd;

    // request handshakes
    always_comb begin
        n_accept  = i_sample.valid && i_sample.ready;
        n_changed = (i_sample.local_time != r_prev_lt);
        n_load    = (r_state == osde_pkg::ST_OUT) && (!r_o_valid || o_result.ready);
        n_d       = i_sample.remote_time - r_prev_rt;
    end

    // shared squarer: dx*dx then dy*dy
    always_comb begin
        n_mul_op   = (r_state == osde_pkg::ST_SQX) ? r_dx : r_dy;
        n_mul      = n_mul_op * n_mul_op;
        n_radicand = r_sq + SQ_W'(n_mul);
    end

    // saturated speed from quotient
    always_comb begin
        n_quot_ext = CMP_W'(quot);
        n_speed    = (n_quot_ext > CMP_W'(osde_pkg::SPEED_MAX)) ? osde_pkg::SPEED_MAX
                                                                : n_quot_ext[osde_pkg::SPEED_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            osde_pkg::ST_IDLE: begin
                if (n_accept) begin
                    n_state = (n_changed && r_primed) ? osde_pkg::ST_SQX : osde_pkg::ST_OUT;
                end
            end
            osde_pkg::ST_SQX:  n_state = osde_pkg::ST_SQY;
            osde_pkg::ST_SQY:  n_state = osde_pkg::ST_ROOT;
            osde_pkg::ST_ROOT: begin
                if (sqrt_done) begin
                    n_state = (r_dt == '0) ? osde_pkg::ST_OUT : osde_pkg::ST_DIV;
                end
            end
            osde_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = (n_speed > osde_pkg::SPEED_W'(r_thr)) ? osde_pkg::ST_DIR
                                                                     : osde_pkg::ST_OUT;
                end
            end
            osde_pkg::ST_DIR:  if (cord_done) n_state = osde_pkg::ST_OUT;
            osde_pkg::ST_OUT:  if (n_load) n_state = osde_pkg::ST_IDLE;
            default:           n_state = osde_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_sample.ready = (r_state == osde_pkg::ST_IDLE);
        sqrt_start     = (r_state == osde_pkg::ST_SQY);
        div_start      = (r_state == osde_pkg::ST_ROOT) && sqrt_done && (r_dt != '0);
        cord_start     = (r_state == osde_pkg::ST_DIV) && div_done
                         && (n_speed > osde_pkg::SPEED_W'(r_thr));
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= osde_pkg::ST_IDLE;
            r_primed  <= 1'b0;
            r_prev_lt <= '0;
            r_prev_rt <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_speed   <= '0;
            r_fwd     <= 1'b1;
            r_thr     <= osde_pkg::THR_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.data;
            end
            if (n_accept && n_changed) begin
                r_primed  <= 1'b1;
                r_prev_lt <= i_sample.local_time;
                r_prev_rt <= i_sample.remote_time;
                r_prev_x  <= i_sample.pos_x;
                r_prev_y  <= i_sample.pos_y;
            end
            if ((r_state == osde_pkg::ST_ROOT) && sqrt_done && (r_dt == '0)) begin
                r_speed <= '0;
            end
            if ((r_state == osde_pkg::ST_DIV) && div_done) begin
                r_speed <= n_speed;
            end
            if ((r_state == osde_pkg::ST_DIR) && cord_done) begin
                r_fwd <= cord_fwd;
            end
            if (n_load) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // sample payload and output register
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_used <= n_changed;
            r_dx   <= D_W'(i_sample.pos_x) - D_W'(r_prev_x);
            r_dy   <= D_W'(i_sample.pos_y) - D_W'(r_prev_y);
            r_hd   <= i_sample.heading;
            r_dt   <= n_d[TW-1] ? (TW'(0) - n_d) : n_d;
        end
        if (r_state == osde_pkg::ST_SQX) begin
            r_sq <= SQ_W'(n_mul);
        end
        if (n_load) begin
            r_o_speed <= r_speed;
            r_o_fwd   <= r_fwd;
            r_o_used  <= r_used;
        end
    end

    osde_sqrt #(.OUT_W(D_W)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (n_radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    osde_div #(.NUM_W(Q_W), .DEN_W(TW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({root, {FRAC_BITS{1'b0}}}),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    osde_cordic #(.D_W(D_W)) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cord_start),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .i_heading (r_hd),
        .o_done    (cord_done),
        .o_forward (cord_fwd)
    );

    assign i_cfg.ready             = 1'b1;
    assign o_result.valid          = r_o_valid;
    assign o_result.speed          = r_o_speed;
    assign o_result.moving_forward = r_o_fwd;
    assign o_result.sample_used    = r_o_used;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Odometry estimator check: random and directed samples, threshold writes
// between phases, results compared against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    typedef struct {
        logic [osde_pkg::SPEED_W-1:0] speed;
        logic                         fwd;
        logic                         used;
    } t_estimate;

    // predictor and store of expected estimates
    class t_odo_scoreboard;
        logic [osde_pkg::THR_W-1:0]   threshold;
        bit                           primed;
        logic [31:0]                  last_local;
        logic [31:0]                  last_remote;
        longint                       last_x;
        longint                       last_y;
        logic [osde_pkg::SPEED_W-1:0] speed_q;
        bit                           fwd_q;
        t_estimate                    pending[$];
        int                           errors;

        function void clear();
            threshold = osde_pkg::THR_RESET;
            primed = 0; last_local = 0; last_remote = 0;
            last_x = 0; last_y = 0; speed_q = 0; fwd_q = 1;
            pending.delete(); errors = 0;
        endfunction

        function longint floor_shift(longint v, int k);
            return v >>> k;
        endfunction

        function bit heading_test(longint dx, longint dy, longint h);
            longint x, y, z, xs, ys;
            x = dx * (64'sd1 << osde_pkg::GUARD_BITS);
            y = dy * (64'sd1 << osde_pkg::GUARD_BITS);
            while (h >= 18000) h -= 36000;
            while (h < -18000) h += 36000;
            if (h > 9000) begin
                x = -x; y = -y; h -= 18000;
            end else if (h < -9000) begin
                x = -x; y = -y; h += 18000;
            end
            z = h * 65536;
            for (int i = 0; i < osde_pkg::CORDIC_ITERS; i++) begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (z >= 0) begin
                    x += ys; y -= xs; z -= longint'(osde_pkg::ATAN_TAB[i]);
                end else begin
                    x -= ys; y += xs; z += longint'(osde_pkg::ATAN_TAB[i]);
                end
            end
            return x > 0;
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b; r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_sample(logic [31:0] lt, logic [31:0] rt, logic signed [15:0] px,
                                  logic signed [15:0] py, logic signed [16:0] hd);
            t_estimate e;
            longint dx, dy;
            longint unsigned span, dt, q;
            logic [31:0] d;
            e.used = 0;
            if (lt != last_local) begin
                e.used = 1;
                if (primed) begin
                    dx = longint'(px) - last_x;
                    dy = longint'(py) - last_y;
                    span = root_floor(longint'(dx * dx) + longint'(dy * dy));
                    d = rt - last_remote;
                    dt = d[31] ? {32'd0, 32'd0 - d} : {32'd0, d};
                    if (dt == 0) speed_q = 0;
                    else begin
                        q = (span << 16) / dt;
                        speed_q = (q > {31'd0, osde_pkg::SPEED_MAX}) ? osde_pkg::SPEED_MAX
                                                                     : q[osde_pkg::SPEED_W-1:0];
                    end
                    if (speed_q > {17'd0, threshold})
                        fwd_q = heading_test(dx, dy, longint'(hd));
                end
                primed = 1; last_local = lt; last_remote = rt;
                last_x = px; last_y = py;
            end
            e.speed = speed_q; e.fwd = fwd_q;
            pending.push_back(e);
        endfunction

        function void check_result(logic [osde_pkg::SPEED_W-1:0] sp, logic fw, logic us);
            t_estimate e;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (sp !== e.speed) begin
                $error("speed exp %0d got %0d", e.speed, sp); errors++;
            end
            if (fw !== e.fwd) begin
                $error("moving_forward exp %0d got %0d", e.fwd, fw); errors++;
            end
            if (us !== e.used) begin
                $error("sample_used exp %0d got %0d", e.used, us); errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    osde_sample_if #(.POS_WIDTH(16)) smp ();
    osde_result_if res ();
    osde_cfg_if    cfg ();

    odometry_speed_direction_estimator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp.sink),
        .o_result (res.source),
        .i_cfg    (cfg.sink)
    );

    t_odo_scoreboard board;
    int send_idle_pct;
    int stall_pct;
    logic [31:0] lt_now, rt_now;
    logic signed [15:0] x_now, y_now;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, checks every accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 0;
        end else begin
            if (res.valid && res.ready)
                board.check_result(res.speed, res.moving_forward, res.sample_used);
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // block is busy the cycle after a request, so the trailing gap costs nothing
    task automatic send_sample(logic [31:0] lt, logic [31:0] rt, logic signed [15:0] px,
                               logic signed [15:0] py, logic signed [16:0] hd);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        smp.valid <= 1;
        smp.local_time <= lt; smp.remote_time <= rt;
        smp.pos_x <= px; smp.pos_y <= py; smp.heading <= hd;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        board.note_sample(lt, rt, px, py, hd);
        smp.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [osde_pkg::THR_W-1:0] v);
        cfg.valid <= 1; cfg.data <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        board.threshold = v;
        cfg.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // well-formed motion: fresh local time, plausible step; sometimes noise
    task automatic random_sample();
        int kind;
        logic signed [16:0] hd;
        kind = $urandom_range(99);
        hd = (kind < 90) ? 17'($signed($urandom_range(72000)) - 36000) : 17'($urandom);
        if (kind < 8) begin
            send_sample(lt_now, $urandom, 16'($urandom), 16'($urandom), hd);
            return;
        end
        lt_now = lt_now + $urandom_range(1, 20);
        if (kind < 70) begin
            rt_now = rt_now + $urandom_range(0, 40);
            x_now = x_now + 16'($signed($urandom_range(400)) - 200);
            y_now = y_now + 16'($signed($urandom_range(400)) - 200);
        end else if (kind < 85) begin
            rt_now = rt_now - $urandom_range(0, 5);
            x_now = 16'($urandom); y_now = 16'($urandom);
        end else begin
            rt_now = $urandom; x_now = 16'($urandom); y_now = 16'($urandom);
        end
        send_sample(lt_now, rt_now, x_now, y_now, hd);
    endtask

    initial begin
        board = new();
        board.clear();
        send_idle_pct = 0; stall_pct = 0;
        i_rst_n = 0;
        smp.valid = 0; smp.local_time = 0; smp.remote_time = 0;
        smp.pos_x = 0; smp.pos_y = 0; smp.heading = 0;
        cfg.valid = 0; cfg.data = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: local time zero ignored, priming, extremes, wrap, overflow
        send_sample(0, 5, 16'sd100, 16'sd100, 17'sd0);
        send_sample(1, 10, 16'sd0, 16'sd0, 17'sd0);
        send_sample(1, 20, 16'sd50, 16'sd50, 17'sd0);
        send_sample(2, 20, 16'sd300, 16'sd0, 17'sd0);
        send_sample(3, 21, 16'sd0, 16'sd0, 17'sd0);
        send_sample(4, 22, 16'sd0, 16'sd0, 17'sd18000);
        send_sample(5, 32'h8000_0016, 16'sd32767, 16'sd32767, -17'sd36000);
        send_sample(6, 32'h0000_0016, 16'sh8000, 16'sh8000, 17'sd36000);
        send_sample(7, 32'h0000_0017, 16'sd32767, 16'sh8000, 17'sd9000);
        send_sample(8, 32'h0000_0016, 16'sh8000, 16'sd32767, -17'sd9000);
        send_sample(9, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 17'sd65535);
        send_sample(32'hFFFF_FFFF, 0, 16'sd10, -16'sd10, 17'sh10000);
        send_sample(32'hFFFF_FFFE, 1, 16'sd20, -16'sd20, 17'sd27000);
        send_sample(32'h8000_0000, 100, 16'sd19, -16'sd20, -17'sd27000);
        send_sample(32'h8000_0001, 101, 16'sd20, -16'sd20, 17'sd4500);
        send_sample(32'h8000_0002, 90, 16'sd0, 16'sd1, 17'sd17999);
        drain();

        lt_now = 32'h8000_0010; rt_now = 200; x_now = 0; y_now = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            case (ph)
                0: write_threshold(16'd0);
                3: write_threshold(16'hFFFF);
                5: write_threshold(osde_pkg::THR_RESET);
                default: write_threshold(osde_pkg::THR_W'($urandom_range(0, 20000)));
            endcase
            repeat (80) random_sample();
            drain();
        end

        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: filelist.f
sv/osde_pkg.sv
sv/osde_if.sv
sv/osde_sqrt.sv
sv/osde_div.sv
sv/osde_cordic.sv
sv/odometry_speed_direction_estimator.sv
tb/tb_top.sv
